[rtl/dllw_pkg.sv]
`default_nettype none
package dllw_pkg;

  localparam int AddrW   = 21;
  localparam int WordW   = 32;
  localparam int NextW   = 24;
  localparam int CountW  = 8;
  localparam int NodesW  = 22;
  localparam int SizeW   = 30;

  localparam logic [NodesW-1:0] MAX_NODES_RESET = NodesW'(2000000);
  localparam logic [SizeW-1:0]  SIZE_MAX        = {SizeW{1'b1}};
  localparam logic [AddrW-1:0]  WORD_STEP       = AddrW'(4);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_RESP  = 1'b1;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } dllw_phase_t;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] start_addr;
    logic [WordW-1:0] read_data;
  } dllw_in_t;

  typedef struct packed {
    logic [1:0]       out_kind;
    logic [AddrW-1:0] mem_addr;
    logic [WordW-1:0] gpu_word;
    logic [SizeW-1:0] total_words;
    logic             aborted;
    logic             last_of_run;
  } dllw_out_t;

  typedef struct packed {
    dllw_phase_t       phase;
    logic [AddrW-1:0]  node_addr;
    logic [NextW-1:0]  next_pointer;
    logic [CountW-1:0] payload_left;
    logic [AddrW-1:0]  payload_addr;
    logic [NodesW-1:0] nodes_visited;
    logic [SizeW-1:0]  size_sum;
  } dllw_state_t;

  // result pair handed from the step logic to the output buffer
  typedef struct packed {
    logic [1:0] count;
    dllw_out_t  first;
    dllw_out_t  second;
  } dllw_pair_t;

endpackage
`default_nettype wire

[rtl/dma_linked_list_walker_core.sv]
`default_nettype none
// Linked-list DMA walker. A start beat gives a list head; the block then
// issues word reads, takes the responses in order on the same input channel,
// and emits read requests, forwarded command words and a done beat with the
// total transfer size. Each input beat is held in an input register and
// resolved combinationally into at most two results, which go to a two-entry
// output buffer. A payload response makes two results and holds the input
// until the second is leaving; the single output port drains the buffer one
// beat per cycle while out_stall is low. A result passes the input register
// and then the buffer register before it reaches the output. max_nodes is
// written over cfg_data at any time cfg_valid is high; cfg_ready is always high.
module dma_linked_list_walker_core
  import dllw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dllw_in_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output dllw_out_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NodesW-1:0] cfg_data
);

  logic [NodesW-1:0] max_nodes;
  dllw_in_t          in_q;
  logic              in_q_valid;
  dllw_state_t       state;
  dllw_state_t       state_next;
  dllw_pair_t        pair;
  logic              can_load;
  logic              take;

  assign cfg_ready = 1'b1;
  assign take      = in_q_valid && can_load;
  assign in_stall  = in_q_valid && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nodes <= MAX_NODES_RESET;
    end else if (cfg_valid) begin
      max_nodes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, node_addr: '0, next_pointer: '0, payload_left: '0,
                 payload_addr: '0, nodes_visited: '0, size_sum: '0};
    end else if (take) begin
      state <= state_next;
    end
  end

  dllw_step u_step (
    .item       (in_q),
    .state      (state),
    .max_nodes  (max_nodes),
    .state_next (state_next),
    .pair       (pair)
  );

  dllw_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .pair      (pair),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[rtl/dllw_step.sv]
`default_nettype none
module dllw_step
  import dllw_pkg::*;
(
  input  dllw_in_t          item,
  input  dllw_state_t       state,
  input  logic [NodesW-1:0] max_nodes,
  output dllw_state_t       state_next,
  output dllw_pair_t        pair
);

  function automatic dllw_out_t read_req(input logic [AddrW-1:0] addr);
    dllw_out_t r;
    r = '0;
    r.out_kind = KIND_READ;
    r.mem_addr = addr;
    return r;
  endfunction

  // follow the next pointer: end of list, node limit, or fetch next header
  function automatic void advance(input dllw_state_t s, input logic [NodesW-1:0] lim,
                                  output dllw_state_t so, output dllw_out_t r);
    so = s;
    r  = '0;
    if (s.next_pointer[NextW-1]) begin
      so.phase      = PH_IDLE;
      r.out_kind    = KIND_DONE;
      r.total_words = s.size_sum;
    end else begin
      so.node_addr = {s.next_pointer[AddrW-1:2], 2'b00};
      if (s.nodes_visited >= lim) begin
        so.phase      = PH_IDLE;
        r.out_kind    = KIND_DONE;
        r.total_words = s.size_sum;
        r.aborted     = 1'b1;
      end else begin
        so.nodes_visited = s.nodes_visited + NodesW'(1);
        so.phase         = PH_HEADER;
        r                = read_req(so.node_addr);
      end
    end
  endfunction

  logic [CountW-1:0] count;
  logic [SizeW:0]    size_add;
  dllw_state_t       hdr;
  dllw_state_t       pay;
  dllw_state_t       adv_state;
  dllw_out_t         adv_res;

  assign count    = item.read_data[WordW-1:WordW-CountW];
  assign size_add = {1'b0, state.size_sum} + (SizeW+1)'({1'b0, count}) + (SizeW+1)'(1);

  always_comb begin
    hdr              = state;
    hdr.next_pointer = item.read_data[NextW-1:0];
    hdr.size_sum     = size_add[SizeW] ? SIZE_MAX : size_add[SizeW-1:0];

    pay              = state;
    pay.payload_left = state.payload_left - CountW'(1);
    pay.payload_addr = state.payload_addr + WORD_STEP;

    if (state.phase == PH_HEADER) begin
      advance(hdr, max_nodes, adv_state, adv_res);
    end else begin
      advance(pay, max_nodes, adv_state, adv_res);
    end
  end

  always_comb begin
    state_next = state;
    pair       = '0;
    if (item.req_type == REQ_START) begin
      state_next.node_addr     = {item.start_addr[AddrW-1:2], 2'b00};
      state_next.nodes_visited = '0;
      state_next.size_sum      = SizeW'(1);
      state_next.payload_left  = '0;
      state_next.phase         = PH_HEADER;
      pair.count               = 2'd1;
      pair.first               = read_req(state_next.node_addr);
      pair.first.last_of_run   = 1'b1;
    end else begin
      case (state.phase)
        PH_HEADER: begin
          pair.count = 2'd1;
          if (count != '0) begin
            state_next              = hdr;
            state_next.payload_left = count;
            state_next.payload_addr = state.node_addr + WORD_STEP;
            state_next.phase        = PH_PAYLOAD;
            pair.first              = read_req(state_next.payload_addr);
          end else begin
            state_next = adv_state;
            pair.first = adv_res;
          end
          pair.first.last_of_run = 1'b1;
        end
        PH_PAYLOAD: begin
          pair.count          = 2'd2;
          pair.first.out_kind = KIND_CMD;
          pair.first.gpu_word = item.read_data;
          if (pay.payload_left != '0) begin
            state_next  = pay;
            pair.second = read_req(pay.payload_addr);
          end else begin
            state_next  = adv_state;
            pair.second = adv_res;
          end
          pair.second.last_of_run = 1'b1;
        end
        default: begin
          // response with no walk in progress
          state_next.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/dllw_out_buf.sv]
`default_nettype none
module dllw_out_buf
  import dllw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  dllw_pair_t pair,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output dllw_out_t  out_item
);

  dllw_out_t  slot0;
  dllw_out_t  slot1;
  logic [1:0] fill;
  logic       pop;

  assign out_valid = fill != 2'd0;
  assign out_item  = slot0;
  assign pop       = out_valid && !out_stall;
  // room for a whole pair once the current beat leaves
  assign can_load  = (fill == 2'd0) || (fill == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load) begin
      fill <= pair.count;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= pair.first;
      slot1 <= pair.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

[rtl/dllw_checker.sv]
`default_nettype none
module dllw_checker
  import dllw_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input dllw_out_t out_item
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output beat changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_kind == KIND_DONE |-> out_item.last_of_run)
    else $error("done beat not marked last");

  // a command word is always the first of a pair, its partner already buffered
  a_cmd_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.out_kind == KIND_CMD
    |-> !out_item.last_of_run ##1 out_valid)
    else $error("command word without following beat");

  a_read_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_kind == KIND_READ |-> out_item.mem_addr[1:0] == 2'b00)
    else $error("unaligned read request");

endmodule

bind dma_linked_list_walker_core dllw_checker u_dllw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
